// ===== hdl/spi_write_then_read_engine_unit_macros.svh =====
// -----------------------------------------------------------------------------
// Assertion macros for the SPI write-then-read engine
// Clocked assertion helpers, with and without a reset guard.
// -----------------------------------------------------------------------------
`ifndef SPI_WRITE_THEN_READ_ENGINE_UNIT_MACROS_SVH
`define SPI_WRITE_THEN_READ_ENGINE_UNIT_MACROS_SVH

// checked only while out of reset
`define SWTR_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every edge, reset included
`define SWTR_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/swtr_pkg.sv =====
// -----------------------------------------------------------------------------
// swtr_pkg
// Types and constants shared by the SPI write-then-read engine.
// -----------------------------------------------------------------------------
package swtr_pkg;

    localparam int BUFFER_BYTES_DEF = 128;
    localparam int PACKET_BYTES_DEF = 4;

    localparam int BYTE_W = 8;
    localparam int BIT_W  = 3;

    // read count saturates here
    localparam logic [BYTE_W-1:0] READ_LIMIT = 8'd128;

    localparam logic [1:0] ACT_PUSH  = 2'd0;
    localparam logic [1:0] ACT_START = 2'd1;
    localparam logic [1:0] ACT_TICK  = 2'd2;

    localparam logic [BIT_W-1:0] LAST_BIT = 3'd7;

    typedef struct packed {
        logic [1:0]        action;
        logic [BYTE_W-1:0] write_byte;
        logic [BYTE_W-1:0] read_count;
        logic              miso_bit;
    } t_req;

    typedef struct packed {
        logic              mosi_bit;
        logic              select_active;
        logic [BYTE_W-1:0] read_byte;
        logic              read_byte_valid;
        logic              packet_end;
        logic              transfer_done;
        logic              error_flag;
    } t_rsp;

endpackage

// ===== hdl/swtr_if.sv =====
// -----------------------------------------------------------------------------
// swtr request / response channels
// Valid-ready channels carrying the engine's request and response payloads.
// -----------------------------------------------------------------------------
interface swtr_req_if;
    logic            valid;
    logic            ready;
    swtr_pkg::t_req  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface swtr_rsp_if;
    logic            valid;
    logic            ready;
    swtr_pkg::t_rsp  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== hdl/swtr_wbuf.sv =====
// -----------------------------------------------------------------------------
// swtr_wbuf
// Write byte buffer: one write port, one read port, registered read data.
// -----------------------------------------------------------------------------
module swtr_wbuf #(
    parameter int DEPTH  = swtr_pkg::BUFFER_BYTES_DEF,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic                      i_clk,
    input  logic                      i_we,
    input  logic [ADDR_W-1:0]         i_waddr,
    input  logic [swtr_pkg::BYTE_W-1:0] i_wdata,
    input  logic                      i_re,
    input  logic [ADDR_W-1:0]         i_raddr,
    output logic [swtr_pkg::BYTE_W-1:0] o_rdata
);

    logic [swtr_pkg::BYTE_W-1:0] r_mem [DEPTH];
    logic [swtr_pkg::BYTE_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read data holds until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/spi_write_then_read_engine_unit.sv =====
// -----------------------------------------------------------------------------
// spi_write_then_read_engine_unit
// Half-duplex SPI master sequencer: buffered write bytes, then read bytes.
// -----------------------------------------------------------------------------
//  channel   dir  handshake          payload
//  i_req     in   valid / ready      action, write_byte, read_count, miso_bit
//  o_rsp     out  valid / ready      mosi_bit ... error_flag, one per request
//
//  One request per cycle sustained unless o_rsp stalls; each response is held in
//  the first stage, then the output register. Control state updates at accept;
//  the buffer read issued then returns next cycle for mosi_bit in stage two.
//  Reset (synchronous, active low) clears counters and both stage valids;
//  buffer contents are undefined until pushed.
//  A stalled o_rsp holds the second stage, then the first, then i_req.ready.
// -----------------------------------------------------------------------------
module spi_write_then_read_engine_unit #(
    parameter int BUFFER_BYTES = swtr_pkg::BUFFER_BYTES_DEF,
    parameter int PACKET_BYTES = swtr_pkg::PACKET_BYTES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    swtr_req_if.sink          i_req,
    swtr_rsp_if.source        o_rsp
);

    localparam int CNT_W  = $clog2(BUFFER_BYTES + 1);
    localparam int ADDR_W = $clog2(BUFFER_BYTES);
    localparam int PKT_W  = $clog2(PACKET_BYTES + 1);
    localparam int BYTE_W = swtr_pkg::BYTE_W;
    localparam int BIT_W  = swtr_pkg::BIT_W;

    // transaction state
    logic [CNT_W-1:0]  r_wtotal, n_wtotal;
    logic [CNT_W-1:0]  r_wpos,   n_wpos;
    logic [BYTE_W-1:0] r_reads,  n_reads;
    logic [BIT_W-1:0]  r_bitpos, n_bitpos;
    logic [PKT_W-1:0]  r_pkt,    n_pkt;
    logic [BYTE_W-1:0] r_rshift, n_rshift;
    logic              r_busy,   n_busy;

    // first stage: waits for buffer read data
    logic              r_a_valid;
    swtr_pkg::t_rsp    r_a_rsp;
    logic              r_a_wr;
    logic [BIT_W-1:0]  r_a_bit;
    swtr_pkg::t_rsp    n_a_rsp;
    logic              n_a_wr;

    // output register
    logic              r_o_valid;
    swtr_pkg::t_rsp    r_o_rsp;
    swtr_pkg::t_rsp    n_o_rsp;

    logic              advance;
    logic              accept;
    logic              buf_we;
    logic              buf_re;
    logic [BYTE_W-1:0] buf_rdata;
    logic [BYTE_W-1:0] rcount_sat;
    logic              writing;

    assign advance = r_a_valid && (!r_o_valid || o_rsp.ready);
    assign i_req.ready = !r_a_valid || advance;
    assign accept = i_req.valid && i_req.ready;

    assign rcount_sat = (i_req.data.read_count > swtr_pkg::READ_LIMIT) ?
                        swtr_pkg::READ_LIMIT : i_req.data.read_count;
    assign writing = r_wpos < r_wtotal;

    always_comb begin
        n_wtotal = r_wtotal;
        n_wpos   = r_wpos;
        n_reads  = r_reads;
        n_bitpos = r_bitpos;
        n_pkt    = r_pkt;
        n_rshift = r_rshift;
        n_busy   = r_busy;
        n_a_rsp  = '0;
        n_a_wr   = 1'b0;
        buf_we   = 1'b0;
        buf_re   = 1'b0;

        case (i_req.data.action)
            swtr_pkg::ACT_PUSH: begin
                if (r_busy || (r_wtotal >= CNT_W'(BUFFER_BYTES))) begin
                    n_a_rsp.error_flag = 1'b1;
                end else begin
                    buf_we   = accept;
                    n_wtotal = r_wtotal + 1'b1;
                end
            end
            swtr_pkg::ACT_START: begin
                if (r_busy) begin
                    n_a_rsp.error_flag = 1'b1;
                end else begin
                    n_wpos   = '0;
                    n_bitpos = '0;
                    n_pkt    = '0;
                    n_rshift = '0;
                    n_reads  = rcount_sat;
                    if ((r_wtotal == '0) && (rcount_sat == '0)) begin
                        n_a_rsp.transfer_done = 1'b1;
                    end else begin
                        n_busy = 1'b1;
                    end
                end
            end
            swtr_pkg::ACT_TICK: begin
                if (!r_busy) begin
                    n_a_rsp.error_flag = 1'b1;
                end else begin
                    n_a_wr = writing;
                    buf_re = accept && writing;
                    if (!writing) begin
                        n_rshift = {r_rshift[BYTE_W-2:0], i_req.data.miso_bit};
                    end
                    if (r_bitpos == swtr_pkg::LAST_BIT) begin
                        n_bitpos = '0;
                        if (writing) begin
                            n_wpos = r_wpos + 1'b1;
                        end else begin
                            n_a_rsp.read_byte       = n_rshift;
                            n_a_rsp.read_byte_valid = 1'b1;
                            n_rshift = '0;
                            if (r_reads != '0) begin
                                n_reads = r_reads - 1'b1;
                            end
                        end
                        n_pkt = r_pkt + 1'b1;
                        if ((n_wpos >= r_wtotal) && (n_reads == '0)) begin
                            n_a_rsp.packet_end    = 1'b1;
                            n_a_rsp.transfer_done = 1'b1;
                            n_busy   = 1'b0;
                            n_wtotal = '0;
                            n_wpos   = '0;
                            n_pkt    = '0;
                        end else if (n_pkt >= PKT_W'(PACKET_BYTES)) begin
                            n_a_rsp.packet_end = 1'b1;
                            n_pkt = '0;
                        end
                    end else begin
                        n_bitpos = r_bitpos + 1'b1;
                    end
                end
            end
            default: begin
                n_a_rsp.error_flag = 1'b1;
            end
        endcase

        n_a_rsp.select_active = n_busy;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wtotal <= '0;
            r_wpos   <= '0;
            r_reads  <= '0;
            r_bitpos <= '0;
            r_pkt    <= '0;
            r_rshift <= '0;
            r_busy   <= 1'b0;
        end else if (accept) begin
            r_wtotal <= n_wtotal;
            r_wpos   <= n_wpos;
            r_reads  <= n_reads;
            r_bitpos <= n_bitpos;
            r_pkt    <= n_pkt;
            r_rshift <= n_rshift;
            r_busy   <= n_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (accept) begin
            r_a_valid <= 1'b1;
        end else if (advance) begin
            r_a_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_a_rsp <= n_a_rsp;
            r_a_wr  <= n_a_wr;
            r_a_bit <= r_bitpos;
        end
    end

    // MSB first
    always_comb begin
        n_o_rsp = r_a_rsp;
        n_o_rsp.mosi_bit = r_a_wr && buf_rdata[swtr_pkg::LAST_BIT - r_a_bit];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (advance) begin
            r_o_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_o_rsp <= n_o_rsp;
        end
    end

    assign o_rsp.valid = r_o_valid;
    assign o_rsp.data  = r_o_rsp;

    swtr_wbuf #(
        .DEPTH  (BUFFER_BYTES),
        .ADDR_W (ADDR_W)
    ) u_wbuf (
        .i_clk   (i_clk),
        .i_we    (buf_we),
        .i_waddr (r_wtotal[ADDR_W-1:0]),
        .i_wdata (i_req.data.write_byte),
        .i_re    (buf_re),
        .i_raddr (r_wpos[ADDR_W-1:0]),
        .o_rdata (buf_rdata)
    );

endmodule

// ===== hdl/swtr_checker.sv =====
// -----------------------------------------------------------------------------
// swtr_checker
// Port-level checks on the response channel of the SPI engine.
// -----------------------------------------------------------------------------
`include "spi_write_then_read_engine_unit_macros.svh"

module swtr_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_o_valid,
    input logic           i_o_ready,
    input swtr_pkg::t_rsp i_o_data
);

    `SWTR_ASSERT(a_rsp_hold, i_clk, i_rst_n, i_o_valid && !i_o_ready |=> i_o_valid && $stable(i_o_data), "stalled response changed")

    `SWTR_ASSERT(a_done_deselect, i_clk, i_rst_n, i_o_valid && i_o_data.transfer_done |-> !i_o_data.select_active, "select still active on done")

    `SWTR_ASSERT(a_err_quiet, i_clk, i_rst_n, i_o_valid && i_o_data.error_flag |-> !i_o_data.transfer_done && !i_o_data.read_byte_valid && !i_o_data.packet_end && !i_o_data.mosi_bit, "ignored request had side effects")

    `SWTR_ASSERT(a_rbyte_zero, i_clk, i_rst_n, i_o_valid && !i_o_data.read_byte_valid |-> i_o_data.read_byte == '0, "read byte without valid")

    `SWTR_ASSERT_ALWAYS(a_reset_idle, i_clk, !i_rst_n |=> !i_o_valid, "response valid after reset")

endmodule

bind spi_write_then_read_engine_unit swtr_checker u_swtr_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .i_o_valid (o_rsp.valid),
    .i_o_ready (o_rsp.ready),
    .i_o_data  (o_rsp.data)
);

// ===== tb/spi_write_then_read_engine_unit_tb.sv =====
`timescale 1ns / 100ps
// -----------------------------------------------------------------------------
// spi_write_then_read_engine_unit_tb
// Drives push, start, bit-tick and spare requests into the engine with random gaps
// on both channels. Each accepted request is run through a cycle-free model of
// the write-then-read sequencer, and every response is checked field by field
// in order.
// -----------------------------------------------------------------------------
module spi_write_then_read_engine_unit_tb;

    localparam int         BYTE_W      = swtr_pkg::BYTE_W;
    localparam int         ADDR_W      = $clog2(swtr_pkg::BUFFER_BYTES_DEF);
    localparam logic [1:0] ACT_SPARE   = 2'd3;   // no operation, always flagged
    localparam int         IDLE_PCT    = 14;
    localparam int         CALM_FROM   = 1500;   // window with no gaps at all
    localparam int         CALM_TO     = 2300;
    localparam int         SETTLE_CYC  = 8;
    localparam int         LIMIT_CYC   = 200000;
    localparam int         SMALL_ITEMS = 360;

    logic i_clk = 1'b0;
    logic i_rst_n;

    swtr_req_if req_if ();
    swtr_rsp_if rsp_if ();

    spi_write_then_read_engine_unit u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if.sink),
        .o_rsp   (rsp_if.source)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // model state
    logic [BYTE_W-1:0]          tx_buffer [swtr_pkg::BUFFER_BYTES_DEF];
    int unsigned                tx_total    = 0;
    int unsigned                tx_sent     = 0;
    int unsigned                rx_left     = 0;
    logic [swtr_pkg::BIT_W-1:0] bit_pos     = '0;
    int unsigned                pkt_bytes   = 0;
    logic [BYTE_W-1:0]          rx_shift    = '0;
    logic                       in_transfer = 1'b0;

    swtr_pkg::t_req queued_requests [$];
    swtr_pkg::t_rsp pending_spi_results [$];

    int   cyc        = 0;
    int   fail_count = 0;
    logic req_taken;

    function automatic swtr_pkg::t_rsp step_spi_master(input swtr_pkg::t_req req);
        swtr_pkg::t_rsp    r;
        logic              writing;
        logic [BYTE_W-1:0] rc;
        r = '0;
        case (req.action)
            swtr_pkg::ACT_PUSH: begin
                if (in_transfer || tx_total >= swtr_pkg::BUFFER_BYTES_DEF) begin
                    r.error_flag = 1'b1;
                end else begin
                    tx_buffer[ADDR_W'(tx_total)] = req.write_byte;
                    tx_total++;
                end
            end
            swtr_pkg::ACT_START: begin
                if (in_transfer) begin
                    r.error_flag = 1'b1;
                end else begin
                    rc = (req.read_count > swtr_pkg::READ_LIMIT) ?
                         swtr_pkg::READ_LIMIT : req.read_count;
                    tx_sent   = 0;
                    bit_pos   = '0;
                    pkt_bytes = 0;
                    rx_shift  = '0;
                    rx_left   = 32'(rc);
                    if (tx_total == 0 && rc == '0)
                        r.transfer_done = 1'b1;
                    else
                        in_transfer = 1'b1;
                end
            end
            swtr_pkg::ACT_TICK: begin
                if (!in_transfer) begin
                    r.error_flag = 1'b1;
                end else begin
                    writing = (tx_sent < tx_total);
                    if (writing)
                        r.mosi_bit = tx_buffer[ADDR_W'(tx_sent)][swtr_pkg::LAST_BIT - bit_pos];
                    else
                        rx_shift = {rx_shift[BYTE_W-2:0], req.miso_bit};
                    if (bit_pos == swtr_pkg::LAST_BIT) begin
                        bit_pos = '0;
                        if (writing) begin
                            tx_sent++;
                        end else begin
                            r.read_byte       = rx_shift;
                            r.read_byte_valid = 1'b1;
                            rx_shift          = '0;
                            if (rx_left > 0)
                                rx_left--;
                        end
                        pkt_bytes++;
                        // last byte of the transaction always closes a packet
                        if (tx_sent >= tx_total && rx_left == 0) begin
                            r.packet_end    = 1'b1;
                            r.transfer_done = 1'b1;
                            in_transfer     = 1'b0;
                            tx_total        = 0;
                            tx_sent         = 0;
                            pkt_bytes       = 0;
                        end else if (pkt_bytes >= swtr_pkg::PACKET_BYTES_DEF) begin
                            r.packet_end = 1'b1;
                            pkt_bytes    = 0;
                        end
                    end else begin
                        bit_pos = bit_pos + 1'b1;
                    end
                end
            end
            default: r.error_flag = 1'b1;
        endcase
        r.select_active = in_transfer;
        return r;
    endfunction

    // request with every field random apart from the action
    function automatic swtr_pkg::t_req rand_req(input logic [1:0] act);
        swtr_pkg::t_req r;
        r.action     = act;
        r.write_byte = BYTE_W'($urandom_range(0, 255));
        r.read_count = BYTE_W'($urandom_range(0, 255));
        r.miso_bit   = 1'($urandom_range(0, 1));
        return r;
    endfunction

    task automatic queue_push(input logic [BYTE_W-1:0] b);
        swtr_pkg::t_req r;
        r = rand_req(swtr_pkg::ACT_PUSH);
        r.write_byte = b;
        queued_requests.push_back(r);
    endtask

    task automatic queue_start(input logic [BYTE_W-1:0] rc);
        swtr_pkg::t_req r;
        r = rand_req(swtr_pkg::ACT_START);
        r.read_count = rc;
        queued_requests.push_back(r);
    endtask

    // ticks for a running transfer; noisy ones get the odd out-of-sequence request
    task automatic queue_ticks(input int n, input bit noisy);
        logic [1:0] act;
        for (int i = 0; i < n; i++) begin
            if (noisy && $urandom_range(0, 99) < 5) begin
                case ($urandom_range(0, 2))
                    0:       act = swtr_pkg::ACT_PUSH;
                    1:       act = swtr_pkg::ACT_START;
                    default: act = ACT_SPARE;
                endcase
                queued_requests.push_back(rand_req(act));
            end
            queued_requests.push_back(rand_req(swtr_pkg::ACT_TICK));
        end
    endtask

    task automatic check_field(input string name, input int exp_v, input int act_v);
        if (exp_v != act_v) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
            fail_count++;
        end
    endtask

    function automatic bit idle_now();
        if (cyc >= CALM_FROM && cyc < CALM_TO)
            return 1'b0;
        return ($urandom_range(0, 99) < IDLE_PCT);
    endfunction

    // request driver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
        end else if (!req_if.valid || req_taken) begin
            if (queued_requests.size() != 0 && !idle_now()) begin
                req_if.valid <= 1'b1;
                req_if.data  <= queued_requests.pop_front();
            end else begin
                req_if.valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n)
            rsp_if.ready <= 1'b0;
        else
            rsp_if.ready <= !idle_now();
    end

    // monitor: predict on request accept, check on response accept
    always @(posedge i_clk) begin
        swtr_pkg::t_rsp exp_r;
        swtr_pkg::t_rsp got;
        if (!i_rst_n) begin
            req_taken <= 1'b0;
        end else begin
            req_taken <= req_if.valid && req_if.ready;
            if (req_if.valid && req_if.ready)
                pending_spi_results.push_back(step_spi_master(req_if.data));
            if (rsp_if.valid && rsp_if.ready) begin
                got = rsp_if.data;
                if (pending_spi_results.size() == 0) begin
                    $error("response with nothing outstanding");
                    fail_count++;
                end else begin
                    exp_r = pending_spi_results.pop_front();
                    check_field("mosi_bit", int'(exp_r.mosi_bit), int'(got.mosi_bit));
                    check_field("select_active", int'(exp_r.select_active),
                                int'(got.select_active));
                    check_field("read_byte", int'(exp_r.read_byte), int'(got.read_byte));
                    check_field("read_byte_valid", int'(exp_r.read_byte_valid),
                                int'(got.read_byte_valid));
                    check_field("packet_end", int'(exp_r.packet_end),
                                int'(got.packet_end));
                    check_field("transfer_done", int'(exp_r.transfer_done),
                                int'(got.transfer_done));
                    check_field("error_flag", int'(exp_r.error_flag),
                                int'(got.error_flag));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cyc <= cyc + 1;
        if (cyc >= LIMIT_CYC) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        int n_wr;
        int n_rd;
        i_rst_n = 1'b0;

        // directed: idle errors, empty start, byte extremes, busy errors
        queued_requests.push_back(rand_req(swtr_pkg::ACT_TICK));
        queued_requests.push_back(rand_req(ACT_SPARE));
        queue_start(8'd0);
        queue_push(8'hFF);
        queue_push(8'h00);
        queue_start(8'd0);
        queued_requests.push_back(rand_req(swtr_pkg::ACT_PUSH));
        queued_requests.push_back(rand_req(swtr_pkg::ACT_START));
        queue_ticks(16, 1'b0);

        // random small transfers, mostly well formed
        while (queued_requests.size() < SMALL_ITEMS) begin
            n_wr = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 12) : $urandom_range(0, 6);
            n_rd = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 12) : $urandom_range(0, 6);
            if ($urandom_range(0, 7) == 0)
                queued_requests.push_back(rand_req($urandom_range(0, 1) ?
                                                   swtr_pkg::ACT_TICK : ACT_SPARE));
            for (int i = 0; i < n_wr; i++)
                queue_push(BYTE_W'($urandom_range(0, 255)));
            queue_start(BYTE_W'(n_rd));
            queue_ticks(8 * (n_wr + n_rd), 1'b1);
        end

        // read count above the limit with nothing to write: ends after the limit
        queue_start(BYTE_W'($urandom_range(int'(swtr_pkg::READ_LIMIT) + 1, 255)));
        queue_ticks(8 * int'(swtr_pkg::READ_LIMIT), 1'b0);

        // full buffer with overflow pushes; still sending when the run ends
        for (int i = 0; i < swtr_pkg::BUFFER_BYTES_DEF + 2; i++)
            queue_push(BYTE_W'($urandom_range(0, 255)));
        queue_start(8'd0);
        queue_ticks(16, 1'b0);

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (queued_requests.size() != 0 || req_if.valid || pending_spi_results.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);

        if (fail_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
